@@ hdl/bir_dec_pkg.sv @@
// Shared types and constants of the bi-phase IR command decoder.
package bir_dec_pkg;

    localparam int TIME_W    = 16;
    localparam int GROUP_W   = 7;
    localparam int GCOUNT_W  = 3;
    localparam int CCOUNT_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD = 1'd1;

    localparam logic [TIME_W-1:0] TIMER_PERIOD_RST   = 16'd12499;
    localparam logic [TIME_W-1:0] LONG_THRESHOLD_RST = 16'd687;

    typedef enum logic [1:0] {
        PH_START_FALL,
        PH_START_RISE,
        PH_BITS,
        PH_LAST_EDGE
    } bir_phase_t;

    typedef struct packed {
        bir_phase_t            phase;
        logic                  expect_bit_edge;
        logic                  bit_value;
        logic [GCOUNT_W-1:0]   group_count;
        logic [CCOUNT_W-1:0]   command_count;
        logic [GROUP_W-1:0]    group_shift;
        logic [TIME_W-1:0]     prev_capture;
    } bir_state_t;

    typedef struct packed {
        logic                  emit;
        logic                  last;
        logic [GROUP_W-1:0]    group;
    } bir_result_t;

endpackage

@@ hdl/bir_dec_cfg_regs.sv @@
// Configuration registers: timer wrap value and long pulse threshold.
module bir_dec_cfg_regs
    import bir_dec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [TIME_W-1:0]    wr_data,
    output logic [TIME_W-1:0]    timer_period,
    output logic [TIME_W-1:0]    long_threshold
);

    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= TIMER_PERIOD_RST;
            threshold_reg <= LONG_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TIMER_PERIOD:   period_reg    <= wr_data;
                REG_LONG_THRESHOLD: threshold_reg <= wr_data;
                default:            ;
            endcase
        end
    end

    assign timer_period   = period_reg;
    assign long_threshold = threshold_reg;

endmodule

@@ hdl/bir_dec_step.sv @@
// Per-edge decode step: interval, pulse class and bi-phase state update.
module bir_dec_step
    import bir_dec_pkg::*;
#(
    parameter int COMMAND_BITS     = 13,
    parameter int FIRST_GROUP_BITS = 7
)
(
    input  bir_state_t          cur,
    input  logic [TIME_W-1:0]   capture,
    input  logic                pin,
    input  logic [TIME_W-1:0]   timer_period,
    input  logic [TIME_W-1:0]   long_threshold,
    output bir_state_t          nxt,
    output bir_result_t         res
);

    logic [TIME_W-1:0]   delta;
    logic                is_long;
    logic                take_bit;
    logic                bit_now;
    logic                expect_tmp;
    logic [GCOUNT_W-1:0] gcount_inc;
    logic [GROUP_W-1:0]  shift_inc;

    // Wrap through the timer period when the capture has rolled over.
    always_comb
    begin
        if (capture >= cur.prev_capture)
            delta = capture - cur.prev_capture;
        else
            delta = timer_period - cur.prev_capture + capture + 16'd1;
    end

    assign is_long    = delta > long_threshold;
    assign take_bit   = is_long || cur.expect_bit_edge;
    assign bit_now    = cur.bit_value ^ is_long;
    assign gcount_inc = cur.group_count + 3'd1;
    assign shift_inc  = {cur.group_shift[GROUP_W-2:0], bit_now};

    always_comb
    begin
        nxt              = cur;
        nxt.prev_capture = capture;
        res              = '0;
        expect_tmp       = cur.expect_bit_edge;
        case (cur.phase)
            PH_START_FALL:
            begin
                nxt.phase = PH_START_RISE;
            end
            PH_START_RISE:
            begin
                if (is_long)
                begin
                    nxt.phase = PH_START_FALL;
                end
                else
                begin
                    nxt.expect_bit_edge = 1'b1;
                    nxt.bit_value       = 1'b1;
                    nxt.group_count     = '0;
                    nxt.group_shift     = '0;
                    nxt.command_count   = '0;
                    nxt.phase           = PH_BITS;
                end
            end
            PH_BITS:
            begin
                if (take_bit)
                begin
                    nxt.bit_value     = bit_now;
                    nxt.group_shift   = shift_inc;
                    nxt.group_count   = gcount_inc;
                    nxt.command_count = cur.command_count + 4'd1;
                    expect_tmp        = 1'b1;
                    // Group full: hand it out and start the next one.
                    if ({1'b0, gcount_inc} == 4'(FIRST_GROUP_BITS))
                    begin
                        res.emit        = 1'b1;
                        res.group       = shift_inc;
                        nxt.group_shift = '0;
                        nxt.group_count = '0;
                    end
                end
                nxt.expect_bit_edge = ~expect_tmp;
                if (nxt.command_count == CCOUNT_W'(COMMAND_BITS))
                begin
                    // Flush any partial group at the end of the command.
                    if (nxt.group_count != '0)
                    begin
                        res.emit  = 1'b1;
                        res.group = nxt.group_shift;
                    end
                    res.last  = res.emit;
                    nxt.phase = pin ? PH_START_FALL : PH_LAST_EDGE;
                end
            end
            default:
            begin
                nxt.phase = PH_START_FALL;
            end
        endcase
    end

endmodule

@@ hdl/biphase_ir_command_decoder_core.sv @@
// Top level of the bi-phase IR command decoder: edge register, decode step, result register.
//
// Each request on the input channel is one edge of the IR receiver: a 16-bit timer
// capture and the pin level after the edge. The block takes one edge per clock unless
// in_stall is high; an edge goes into an input register, is decoded from there and its
// group, if the edge completes one, is written into the result register when the held
// edge advances, and out_valid then offers it. The input stalls only while a result
// waits under out_stall and a further edge is already held. A command gives two results:
// the 7-bit start/toggle/address group and then the 6-bit data group flagged by
// last_of_command. The timer period and long pulse threshold are written through the
// configuration channel (index 0 and 1), which is always ready; write them only while
// no edge is in flight.
module biphase_ir_command_decoder_core
    import bir_dec_pkg::*;
#(
    parameter int COMMAND_BITS     = 13,
    parameter int FIRST_GROUP_BITS = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_W-1:0]    capture_time,
    input  logic                 pin_level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [GROUP_W-1:0]   code_group,
    output logic                 last_of_command,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    logic [TIME_W-1:0]  timer_period;
    logic [TIME_W-1:0]  long_threshold;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [TIME_W-1:0]  capture_reg;
    logic               pin_reg;

    bir_state_t         state_reg;
    bir_state_t         state_next;
    bir_result_t        step_res;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [GROUP_W-1:0] group_reg;
    logic               last_reg;

    logic               in_take;
    logic               advance;

    assign cfg_ready = 1'b1;

    bir_dec_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (cfg_valid && cfg_ready),
        .wr_index       (cfg_index),
        .wr_data        (cfg_data),
        .timer_period   (timer_period),
        .long_threshold (long_threshold)
    );

    bir_dec_step #(
        .COMMAND_BITS     (COMMAND_BITS),
        .FIRST_GROUP_BITS (FIRST_GROUP_BITS)
    ) u_step (
        .cur            (state_reg),
        .capture        (capture_reg),
        .pin            (pin_reg),
        .timer_period   (timer_period),
        .long_threshold (long_threshold),
        .nxt            (state_next),
        .res            (step_res)
    );

    // Advance the held edge unless a result is still waiting downstream.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        if (advance)
            out_valid_next = step_res.emit;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_START_FALL, default: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            capture_reg <= capture_time;
            pin_reg     <= pin_level;
        end
        if (advance && step_res.emit)
        begin
            group_reg <= step_res.group;
            last_reg  <= step_res.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign code_group      = group_reg;
    assign last_of_command = last_reg;

    // Input back-pressure only ever comes from a blocked result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // A group never stays full in the shift register.
    a_group_count: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, state_reg.group_count} < 4'(FIRST_GROUP_BITS)))
        else $error("group bit count reached group size");

    // The bit phase is left as soon as the command is complete.
    a_command_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_BITS) |-> (state_reg.command_count < 4'(COMMAND_BITS)))
        else $error("bit phase held past command end");

    // A result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(group_reg)
                                          && $stable(last_reg)))
        else $error("pending result lost or changed");

endmodule
